[sv/stack_machine_instruction_executor_macros.svh]
// assertion macros for the stack machine instruction executor
// used by the top level, which provides clk and rst_n
`ifndef STACK_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH

// same-cycle implication
`define SMIE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/smie_pkg.sv]
// types and codes of the stack machine instruction executor
// no dependencies; used by the top level
`default_nettype none

package smie_pkg;

    typedef enum logic [5:0] {
        OP_AMEM = 6'd0,  OP_ARMI = 6'd1,  OP_ARMZ = 6'd2,  OP_CHPR = 6'd3,
        OP_CMAG = 6'd4,  OP_CMDG = 6'd5,  OP_CMEG = 6'd6,  OP_CMIG = 6'd7,
        OP_CMMA = 6'd8,  OP_CMME = 6'd9,  OP_CONJ = 6'd10, OP_CRCT = 6'd11,
        OP_CREN = 6'd12, OP_CRVI = 6'd13, OP_CRVL = 6'd14, OP_DISJ = 6'd15,
        OP_DIVI = 6'd16, OP_DMEM = 6'd17, OP_DSVF = 6'd18, OP_DSVR = 6'd19,
        OP_DSVS = 6'd20, OP_ENPR = 6'd21, OP_ENRT = 6'd22, OP_IMPR = 6'd23,
        OP_INPP = 6'd24, OP_INVR = 6'd25, OP_LEIT = 6'd26, OP_MULT = 6'd27,
        OP_NADA = 6'd28, OP_NEGA = 6'd29, OP_PARA = 6'd30, OP_RTPR = 6'd31,
        OP_SOMA = 6'd32, OP_SUBT = 6'd33
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_HALT  = 2'd1,
        ST_DIV0  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD1, S_RD2, S_MDU, S_WR2, S_UNW, S_UNW1, S_UNW2, S_FIN
    } state_t;

    typedef struct packed {
        logic [5:0]         opcode;
        logic signed [31:0] first_operand;
        logic signed [31:0] second_operand;
        logic [3:0]         third_operand;
        logic [9:0]         branch_target;
        logic signed [31:0] read_value;
    } instr_t;

    typedef struct packed {
        logic [9:0]         next_pc;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic [1:0]         status;
    } result_t;

endpackage

`default_nettype wire

[sv/smie_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module smie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/smie_mdu.sv]
// iterative multiply and signed divide unit, one bit per cycle
// no dependencies; used by the top level
`default_nettype none

module smie_mdu #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             is_div,
    input  wire logic [WIDTH-1:0] lhs,
    input  wire logic [WIDTH-1:0] rhs,
    output logic                  done,
    output logic      [WIDTH-1:0] result
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             div_reg, div_next;
    logic             neg_reg, neg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] opa_reg, opa_next;
    logic [WIDTH-1:0] opb_reg, opb_next;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH-1:0] lhs_mag, rhs_mag;

    assign lhs_mag = lhs[WIDTH-1] ? (~lhs + 1'b1) : lhs;
    assign rhs_mag = rhs[WIDTH-1] ? (~rhs + 1'b1) : rhs;
    assign rem_sh  = {acc_reg, opa_reg[WIDTH-1]};

    assign done   = busy_reg && (cnt_reg == '0);
    assign result = div_reg ? (neg_reg ? (~opa_reg + 1'b1) : opa_reg) : acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        if (start)
        begin
            busy_next = 1'b1;
            div_next  = is_div;
            neg_next  = lhs[WIDTH-1] ^ rhs[WIDTH-1];
            cnt_next  = CW'(WIDTH);
            acc_next  = '0;
            // divide: opa is dividend then quotient, opb divisor
            // multiply: opa is multiplier, opb the shifting multiplicand
            opa_next  = is_div ? lhs_mag : rhs;
            opb_next  = is_div ? rhs_mag : lhs;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (div_reg)
            begin
                if (rem_sh >= {1'b0, opb_reg})
                begin
                    acc_next = WIDTH'(rem_sh - {1'b0, opb_reg});
                    opa_next = {opa_reg[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next = WIDTH'(rem_sh);
                    opa_next = {opa_reg[WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                if (opa_reg[0])
                begin
                    acc_next = acc_reg + opb_reg;
                end
                opa_next = opa_reg >> 1;
                opb_next = opb_reg << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
    end

endmodule

`default_nettype wire

[sv/stack_machine_instruction_executor.sv]
// mult and divi run on the bit-serial unit, and dsvr unwinds the display one level at a time
// one item in flight: the next is accepted in the cycle after the result register loads
// reset: pc 0, stack pointer -1, display all zero; data memory is not cleared.
// depends on smie_pkg, smie_ram, smie_mdu and the assertion macro header
`default_nettype none
`include "stack_machine_instruction_executor_macros.svh"

module stack_machine_instruction_executor #(
    parameter int PROG_DEPTH = 1024,
    parameter int MEM_DEPTH  = 4096,
    parameter int LEVELS     = 16,
    parameter int WORD_BITS  = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             instr_valid,
    output logic                  instr_stall,
    input  wire smie_pkg::instr_t instr,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output smie_pkg::result_t     result
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int SW  = AW + 1;
    localparam int PCW = $clog2(PROG_DEPTH);
    localparam int LW  = $clog2(LEVELS);
    localparam int SCW = $clog2(LEVELS + 1);
    localparam int WB  = WORD_BITS;
    localparam int XW  = 68;

    function automatic logic addr_ok(input logic signed [XW-1:0] v);
        return (v >= 0) && (v < XW'(MEM_DEPTH));
    endfunction

    function automatic logic top_ok(input logic signed [XW-1:0] v);
        return (v == -1) || addr_ok(v);
    endfunction

    function automatic logic level_ok(input logic signed [XW-1:0] v);
        return (v >= 0) && (v < XW'(LEVELS));
    endfunction

    function automatic logic code_ok(input logic signed [XW-1:0] v);
        return (v >= 0) && (v < XW'(PROG_DEPTH));
    endfunction

    function automatic logic [WB-1:0] alu_fn(input logic [5:0] op,
                                             input logic [WB-1:0] x,
                                             input logic [WB-1:0] y);
        logic signed [WB-1:0] a;
        logic signed [WB-1:0] b;
        a = $signed(x);
        b = $signed(y);
        case (op)
            smie_pkg::OP_CMAG: return WB'(a >= b);
            smie_pkg::OP_CMDG: return WB'(a != b);
            smie_pkg::OP_CMEG: return WB'(a <= b);
            smie_pkg::OP_CMIG: return WB'(a == b);
            smie_pkg::OP_CMMA: return WB'(a > b);
            smie_pkg::OP_CMME: return WB'(a < b);
            smie_pkg::OP_CONJ: return WB'((x != '0) && (y != '0));
            smie_pkg::OP_DISJ: return WB'((x != '0) || (y != '0));
            smie_pkg::OP_SOMA: return x + y;
            default:           return x - y;
        endcase
    endfunction

    smie_pkg::state_t  state_reg, state_next;
    smie_pkg::status_t step_st;
    smie_pkg::status_t st_reg, st_next;

    logic [5:0]           op_reg, op_next;
    logic signed [31:0]   k_reg, k_next;
    logic signed [31:0]   n_reg, n_next;
    logic [3:0]           dest_reg, dest_next;
    logic [9:0]           tgt_reg, tgt_next;
    logic signed [31:0]   rv_reg, rv_next;

    logic [PCW-1:0]       pc_reg, pc_next;
    logic signed [AW:0]   sp_reg, sp_next;
    logic [AW-1:0]        display_reg [LEVELS];
    logic [AW-1:0]        display_next [LEVELS];
    logic [AW-1:0]        tmp_reg [LEVELS];
    logic [AW-1:0]        tmp_next [LEVELS];
    logic [WB-1:0]        va_reg, va_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic signed [63:0]   cur_reg, cur_next;
    logic [SCW-1:0]       steps_reg, steps_next;
    logic                 pv_reg, pv_next;
    logic [31:0]          pval_reg, pval_next;

    logic                 result_valid_reg, result_valid_next;
    smie_pkg::result_t    result_reg, result_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WB-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WB-1:0]        rdata;

    logic                 mdu_start;
    logic                 mdu_done;
    logic [WB-1:0]        mdu_result;

    logic signed [XW-1:0] sp_x, k_x, n_x, disp_x, slot_x, rd_x, va_x, cur_x, base_x;
    logic [LW-1:0]        k_idx, cur_idx;
    logic [AW-1:0]        disp_k;
    logic                 k_ok, slot_ok, tgt_ok, push1_ok, push2_ok;
    logic [PCW-1:0]       pc_inc;
    logic                 op_iter;

    assign k_idx    = k_reg[LW-1:0];
    assign cur_idx  = cur_reg[LW-1:0];
    assign disp_k   = display_reg[k_idx];
    assign sp_x     = XW'(sp_reg);
    assign k_x      = XW'(k_reg);
    assign n_x      = XW'(n_reg);
    assign disp_x   = $signed(XW'(disp_k));
    assign slot_x   = disp_x + n_x;
    assign rd_x     = XW'($signed(rdata));
    assign va_x     = XW'($signed(va_reg));
    assign cur_x    = XW'(cur_reg);
    assign base_x   = $signed(XW'(tmp_reg[cur_idx]));
    assign k_ok     = level_ok(k_x);
    assign slot_ok  = k_ok && addr_ok(slot_x);
    assign tgt_ok   = code_ok($signed(XW'(tgt_reg)));
    assign push1_ok = (sp_x + 1) < XW'(MEM_DEPTH);
    assign push2_ok = (sp_x + 2) < XW'(MEM_DEPTH);
    assign pc_inc   = (pc_reg == PCW'(PROG_DEPTH - 1)) ? '0 : pc_reg + 1'b1;
    assign op_iter  = op_reg inside {smie_pkg::OP_DIVI, smie_pkg::OP_MULT};

    assign instr_stall  = (state_reg != smie_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    smie_ram #(
        .WIDTH (WB),
        .DEPTH (MEM_DEPTH)
    ) u_dmem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    smie_mdu #(
        .WIDTH (WB)
    ) u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mdu_start),
        .is_div (op_reg == smie_pkg::OP_DIVI),
        .lhs    (va_reg),
        .rhs    (rdata),
        .done   (mdu_done),
        .result (mdu_result)
    );

    // next state and status of the current step
    always_comb
    begin
        state_next = state_reg;
        step_st    = smie_pkg::ST_OK;
        case (state_reg)
            smie_pkg::S_IDLE:
            begin
                if (instr_valid)
                begin
                    state_next = smie_pkg::S_DEC;
                end
            end
            smie_pkg::S_DEC:
            begin
                state_next = smie_pkg::S_FIN;
                case (op_reg)
                    smie_pkg::OP_AMEM:
                        if (!top_ok(sp_x + k_x)) step_st = smie_pkg::ST_RANGE;
                    smie_pkg::OP_DMEM:
                        if (!top_ok(sp_x - k_x)) step_st = smie_pkg::ST_RANGE;
                    smie_pkg::OP_ARMI, smie_pkg::OP_ARMZ:
                        if (sp_reg[AW] || !slot_ok) step_st = smie_pkg::ST_RANGE;
                        else state_next = smie_pkg::S_RD1;
                    smie_pkg::OP_CHPR:
                        if (!push2_ok || !tgt_ok) step_st = smie_pkg::ST_RANGE;
                        else state_next = smie_pkg::S_WR2;
                    smie_pkg::OP_CMAG, smie_pkg::OP_CMDG, smie_pkg::OP_CMEG,
                    smie_pkg::OP_CMIG, smie_pkg::OP_CMMA, smie_pkg::OP_CMME,
                    smie_pkg::OP_CONJ, smie_pkg::OP_DISJ, smie_pkg::OP_DIVI,
                    smie_pkg::OP_MULT, smie_pkg::OP_SOMA, smie_pkg::OP_SUBT:
                        if (sp_x < 1) step_st = smie_pkg::ST_RANGE;
                        else state_next = smie_pkg::S_RD1;
                    smie_pkg::OP_CRCT, smie_pkg::OP_LEIT:
                        if (!push1_ok) step_st = smie_pkg::ST_RANGE;
                    smie_pkg::OP_CREN:
                        if (!push1_ok || !k_ok) step_st = smie_pkg::ST_RANGE;
                    smie_pkg::OP_CRVI, smie_pkg::OP_CRVL:
                        if (!push1_ok || !slot_ok) step_st = smie_pkg::ST_RANGE;
                        else state_next = smie_pkg::S_RD1;
                    smie_pkg::OP_DSVF, smie_pkg::OP_IMPR, smie_pkg::OP_INVR,
                    smie_pkg::OP_NEGA:
                        if (sp_reg[AW]) step_st = smie_pkg::ST_RANGE;
                        else state_next = smie_pkg::S_RD1;
                    smie_pkg::OP_RTPR:
                        if ((sp_x < 2) || !k_ok) step_st = smie_pkg::ST_RANGE;
                        else state_next = smie_pkg::S_RD1;
                    smie_pkg::OP_DSVR:
                        if (!tgt_ok) step_st = smie_pkg::ST_RANGE;
                        else state_next = smie_pkg::S_UNW;
                    smie_pkg::OP_DSVS:
                        if (!tgt_ok) step_st = smie_pkg::ST_RANGE;
                    smie_pkg::OP_ENPR:
                        if (!push2_ok || !k_ok) step_st = smie_pkg::ST_RANGE;
                    smie_pkg::OP_ENRT:
                        if (!k_ok || !top_ok(slot_x - 1)) step_st = smie_pkg::ST_RANGE;
                    smie_pkg::OP_PARA:
                        step_st = smie_pkg::ST_HALT;
                    default:
                        ;
                endcase
            end
            smie_pkg::S_RD1:
            begin
                state_next = smie_pkg::S_FIN;
                case (op_reg)
                    smie_pkg::OP_ARMI, smie_pkg::OP_RTPR,
                    smie_pkg::OP_CMAG, smie_pkg::OP_CMDG, smie_pkg::OP_CMEG,
                    smie_pkg::OP_CMIG, smie_pkg::OP_CMMA, smie_pkg::OP_CMME,
                    smie_pkg::OP_CONJ, smie_pkg::OP_DISJ, smie_pkg::OP_DIVI,
                    smie_pkg::OP_MULT, smie_pkg::OP_SOMA, smie_pkg::OP_SUBT:
                        state_next = smie_pkg::S_RD2;
                    smie_pkg::OP_CRVI:
                        if (!addr_ok(rd_x)) step_st = smie_pkg::ST_RANGE;
                        else state_next = smie_pkg::S_RD2;
                    smie_pkg::OP_DSVF:
                        if ((rdata == '0) && !tgt_ok) step_st = smie_pkg::ST_RANGE;
                    default:
                        ;
                endcase
            end
            smie_pkg::S_RD2:
            begin
                state_next = smie_pkg::S_FIN;
                case (op_reg)
                    smie_pkg::OP_ARMI:
                        if (!addr_ok(rd_x)) step_st = smie_pkg::ST_RANGE;
                    smie_pkg::OP_DIVI:
                        if (rdata == '0) step_st = smie_pkg::ST_DIV0;
                        else state_next = smie_pkg::S_MDU;
                    smie_pkg::OP_MULT:
                        state_next = smie_pkg::S_MDU;
                    smie_pkg::OP_RTPR:
                        if (!addr_ok(va_x) || !code_ok(rd_x) || !top_ok(sp_x - (n_x + 3)))
                            step_st = smie_pkg::ST_RANGE;
                    default:
                        ;
                endcase
            end
            smie_pkg::S_MDU:
            begin
                if (mdu_done)
                begin
                    state_next = smie_pkg::S_FIN;
                end
            end
            smie_pkg::S_WR2:
            begin
                state_next = smie_pkg::S_FIN;
            end
            smie_pkg::S_UNW:
            begin
                if (cur_x == $signed(XW'(dest_reg)))
                begin
                    state_next = smie_pkg::S_FIN;
                end
                else if ((steps_reg >= SCW'(LEVELS)) || !level_ok(cur_x)
                         || !addr_ok(base_x - 2))
                begin
                    step_st    = smie_pkg::ST_RANGE;
                    state_next = smie_pkg::S_FIN;
                end
                else
                begin
                    state_next = smie_pkg::S_UNW1;
                end
            end
            smie_pkg::S_UNW1:
            begin
                state_next = smie_pkg::S_UNW2;
            end
            smie_pkg::S_UNW2:
            begin
                if (!addr_ok(rd_x))
                begin
                    step_st    = smie_pkg::ST_RANGE;
                    state_next = smie_pkg::S_FIN;
                end
                else
                begin
                    state_next = smie_pkg::S_UNW;
                end
            end
            smie_pkg::S_FIN:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = smie_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = smie_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory port and result register
    always_comb
    begin
        op_next           = op_reg;
        k_next            = k_reg;
        n_next            = n_reg;
        dest_next         = dest_reg;
        tgt_next          = tgt_reg;
        rv_next           = rv_reg;
        pc_next           = pc_reg;
        sp_next           = sp_reg;
        display_next      = display_reg;
        tmp_next          = tmp_reg;
        va_next           = va_reg;
        addr_next         = addr_reg;
        cur_next          = cur_reg;
        steps_next        = steps_reg;
        pv_next           = pv_reg;
        pval_next         = pval_reg;
        st_next           = st_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = '0;
        ram_raddr         = '0;
        mdu_start         = 1'b0;

        // the step that ends the work records the status and, if the status is ok, advances the pc
        if ((state_reg != smie_pkg::S_FIN) && (state_next == smie_pkg::S_FIN))
        begin
            st_next = step_st;
            if (step_st == smie_pkg::ST_OK)
            begin
                pc_next = pc_inc;
            end
        end

        case (state_reg)
            smie_pkg::S_IDLE:
            begin
                if (instr_valid)
                begin
                    op_next   = instr.opcode;
                    k_next    = instr.first_operand;
                    n_next    = instr.second_operand;
                    dest_next = instr.third_operand;
                    tgt_next  = instr.branch_target;
                    rv_next   = instr.read_value;
                    pv_next   = 1'b0;
                    pval_next = '0;
                end
            end
            smie_pkg::S_DEC:
            begin
                if (step_st == smie_pkg::ST_OK)
                begin
                    case (op_reg)
                        smie_pkg::OP_AMEM:
                            sp_next = SW'(sp_x + k_x);
                        smie_pkg::OP_DMEM:
                            sp_next = SW'(sp_x - k_x);
                        smie_pkg::OP_ARMI, smie_pkg::OP_ARMZ:
                        begin
                            ram_raddr = AW'(sp_reg);
                            addr_next = AW'(slot_x);
                        end
                        smie_pkg::OP_CHPR:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(sp_x + 1);
                            ram_wdata = WB'(pc_inc);
                        end
                        smie_pkg::OP_CMAG, smie_pkg::OP_CMDG, smie_pkg::OP_CMEG,
                        smie_pkg::OP_CMIG, smie_pkg::OP_CMMA, smie_pkg::OP_CMME,
                        smie_pkg::OP_CONJ, smie_pkg::OP_DISJ, smie_pkg::OP_DIVI,
                        smie_pkg::OP_MULT, smie_pkg::OP_SOMA, smie_pkg::OP_SUBT:
                            ram_raddr = AW'(sp_x - 1);
                        smie_pkg::OP_CRCT, smie_pkg::OP_LEIT, smie_pkg::OP_CREN:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(sp_x + 1);
                            if (op_reg == smie_pkg::OP_CRCT) ram_wdata = WB'(k_reg);
                            else if (op_reg == smie_pkg::OP_LEIT) ram_wdata = WB'(rv_reg);
                            else ram_wdata = WB'(slot_x);
                            sp_next   = SW'(sp_x + 1);
                        end
                        smie_pkg::OP_CRVI, smie_pkg::OP_CRVL:
                            ram_raddr = AW'(slot_x);
                        smie_pkg::OP_DSVF, smie_pkg::OP_IMPR, smie_pkg::OP_INVR,
                        smie_pkg::OP_NEGA, smie_pkg::OP_RTPR:
                            ram_raddr = AW'(sp_reg);
                        smie_pkg::OP_DSVR:
                        begin
                            tmp_next   = display_reg;
                            cur_next   = 64'(n_reg);
                            steps_next = '0;
                        end
                        smie_pkg::OP_DSVS:
                            pc_next = PCW'(tgt_reg);
                        smie_pkg::OP_ENPR:
                        begin
                            ram_we              = 1'b1;
                            ram_waddr           = AW'(sp_x + 1);
                            ram_wdata           = WB'(disp_k);
                            display_next[k_idx] = AW'(sp_x + 2);
                            sp_next             = SW'(sp_x + 1);
                        end
                        smie_pkg::OP_ENRT:
                            sp_next = SW'(slot_x - 1);
                        smie_pkg::OP_INPP:
                        begin
                            sp_next         = '1;
                            display_next[0] = '0;
                        end
                        default:
                            ;
                    endcase
                end
            end
            smie_pkg::S_RD1:
            begin
                if (step_st == smie_pkg::ST_OK)
                begin
                    case (op_reg)
                        smie_pkg::OP_ARMI:
                        begin
                            va_next   = rdata;
                            ram_raddr = addr_reg;
                        end
                        smie_pkg::OP_ARMZ:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = addr_reg;
                            ram_wdata = rdata;
                            sp_next   = sp_reg - 1'b1;
                        end
                        smie_pkg::OP_CRVL:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(sp_x + 1);
                            ram_wdata = rdata;
                            sp_next   = SW'(sp_x + 1);
                        end
                        smie_pkg::OP_CRVI:
                            ram_raddr = AW'(rd_x);
                        smie_pkg::OP_DSVF:
                        begin
                            if (rdata == '0) pc_next = PCW'(tgt_reg);
                            sp_next = sp_reg - 1'b1;
                        end
                        smie_pkg::OP_IMPR:
                        begin
                            pv_next   = 1'b1;
                            pval_next = 32'(rdata);
                            sp_next   = sp_reg - 1'b1;
                        end
                        smie_pkg::OP_INVR, smie_pkg::OP_NEGA:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(sp_reg);
                            ram_wdata = (op_reg == smie_pkg::OP_NEGA)
                                        ? (WB'(1) - rdata) : (WB'(0) - rdata);
                        end
                        smie_pkg::OP_RTPR:
                        begin
                            va_next   = rdata;
                            ram_raddr = AW'(sp_x - 2);
                        end
                        default:
                        begin
                            // binary operations: left operand, then fetch the top
                            va_next   = rdata;
                            ram_raddr = AW'(sp_reg);
                        end
                    endcase
                end
            end
            smie_pkg::S_RD2:
            begin
                if (step_st == smie_pkg::ST_OK)
                begin
                    case (op_reg)
                        smie_pkg::OP_ARMI:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(rd_x);
                            ram_wdata = va_reg;
                            sp_next   = sp_reg - 1'b1;
                        end
                        smie_pkg::OP_CRVI:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(sp_x + 1);
                            ram_wdata = rdata;
                            sp_next   = SW'(sp_x + 1);
                        end
                        smie_pkg::OP_RTPR:
                        begin
                            display_next[k_idx] = AW'(va_x);
                            sp_next             = SW'(sp_x - (n_x + 3));
                            pc_next             = PCW'(rd_x);
                        end
                        default:
                        begin
                            if (op_iter)
                            begin
                                mdu_start = 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(sp_x - 1);
                                ram_wdata = alu_fn(op_reg, va_reg, rdata);
                                sp_next   = sp_reg - 1'b1;
                            end
                        end
                    endcase
                end
            end
            smie_pkg::S_MDU:
            begin
                if (mdu_done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(sp_x - 1);
                    ram_wdata = mdu_result;
                    sp_next   = sp_reg - 1'b1;
                end
            end
            smie_pkg::S_WR2:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(sp_x + 2);
                ram_wdata = WB'(n_reg);
                sp_next   = SW'(sp_x + 2);
                pc_next   = PCW'(tgt_reg);
            end
            smie_pkg::S_UNW:
            begin
                if (cur_x == $signed(XW'(dest_reg)))
                begin
                    display_next = tmp_reg;
                    pc_next      = PCW'(tgt_reg);
                end
                else if (step_st == smie_pkg::ST_OK)
                begin
                    // static link at base-2, saved display entry at base-1
                    ram_raddr = AW'(base_x - 2);
                    addr_next = AW'(base_x - 1);
                end
            end
            smie_pkg::S_UNW1:
            begin
                va_next   = rdata;
                ram_raddr = addr_reg;
            end
            smie_pkg::S_UNW2:
            begin
                if (step_st == smie_pkg::ST_OK)
                begin
                    tmp_next[cur_idx] = AW'(rd_x);
                    cur_next          = 64'($signed(va_reg));
                    steps_next        = steps_reg + 1'b1;
                end
            end
            smie_pkg::S_FIN:
            begin
                if (state_next == smie_pkg::S_IDLE)
                begin
                    result_next.next_pc     = 10'(pc_reg);
                    result_next.print_valid = pv_reg;
                    result_next.print_value = $signed(pval_reg);
                    result_next.status      = st_reg;
                    result_valid_next       = 1'b1;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= smie_pkg::S_IDLE;
            pc_reg           <= '0;
            sp_reg           <= '1;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                display_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            pc_reg           <= pc_next;
            sp_reg           <= sp_next;
            result_valid_reg <= result_valid_next;
            display_reg      <= display_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        dest_reg   <= dest_next;
        tgt_reg    <= tgt_next;
        rv_reg     <= rv_next;
        tmp_reg    <= tmp_next;
        va_reg     <= va_next;
        addr_reg   <= addr_next;
        cur_reg    <= cur_next;
        steps_reg  <= steps_next;
        pv_reg     <= pv_next;
        pval_reg   <= pval_next;
        st_reg     <= st_next;
        result_reg <= result_next;
    end

    `SMIE_ASSERT_NOW(a_sp_range, 1'b1,
        (sp_reg >= -1) && (sp_x < XW'(MEM_DEPTH)),
        "stack pointer out of range")
    `SMIE_ASSERT_NEXT(a_fault_keeps_state,
        (state_reg != smie_pkg::S_FIN) && (state_next == smie_pkg::S_FIN)
            && (step_st != smie_pkg::ST_OK),
        $stable(sp_reg) && $stable(pc_reg),
        "faulting item changed state")
    `SMIE_ASSERT_NEXT(a_mdu_start, mdu_start, state_reg == smie_pkg::S_MDU,
        "mdu started outside its step")
    `SMIE_ASSERT_NOW(a_no_idle_write, state_reg == smie_pkg::S_IDLE, !ram_we,
        "memory written while idle")

endmodule

`default_nettype wire
